// File: src/rmv_pkg.sv
// rmv_pkg: shared request type and adder width for the running mean and variance block
// no dependencies

package rmv_pkg;

  localparam int unsigned AluW = 68;

  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            sub;
  } rmv_alu_req_t;

endpackage

// File: src/rmv_if.sv
// rmv_in_if and rmv_out_if: valid/ready channels of the block
// no dependencies

interface rmv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface rmv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_count;
  logic [31:0] mean_value;
  logic [63:0] sample_variance;
  logic [31:0] std_deviation;
  logic        variance_valid;
  modport source (output valid, output sample_count, output mean_value,
                  output sample_variance, output std_deviation,
                  output variance_valid, input ready);
  modport sink (input valid, input sample_count, input mean_value,
                input sample_variance, input std_deviation,
                input variance_valid, output ready);
endinterface

// File: src/rmv_alu.sv
// rmv_alu: shared add/subtract unit used by every arithmetic sequencer step
// depends on rmv_pkg

module rmv_alu (
  input  rmv_pkg::rmv_alu_req_t         req,
  output logic [rmv_pkg::AluW-1:0]      y
);
  import rmv_pkg::*;

  assign y = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// File: src/rmv_core.sv
// rmv_core: sequencer for the welford update, divisions, multiply and sqrt
// depends on rmv_pkg, rmv_alu

module rmv_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  rmv_in_if.sink    in_ch,
  rmv_out_if.source out_ch
);
  import rmv_pkg::*;

  localparam int SampleBits = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int ShAmt      = 32 - SampleBits;

  typedef enum logic [3:0] {
    S_IDLE, S_DELTA, S_DIV1, S_MEAN, S_ERR, S_MUL, S_ACC, S_DIV2, S_SQRT, S_DONE
  } state_t;

  state_t       state_r;
  logic [32:0]  x_r;
  logic [31:0]  mean_r;
  logic [63:0]  m2_r;
  logic [31:0]  cnt_r;
  logic         dneg_r;
  logic [32:0]  dmag_r;
  logic [35:0]  rem_r;
  logic [65:0]  wq_r;
  logic [31:0]  root_r;
  logic [6:0]   iter_r;
  logic [63:0]  var_r;

  logic               out_valid_r;
  logic [31:0]        o_cnt_r;
  logic [31:0]        o_mean_r;
  logic [63:0]        o_var_r;
  logic [31:0]        o_sd_r;
  logic               o_vv_r;

  rmv_alu_req_t   req;
  logic [AluW-1:0] y;
  logic [31:0]    xs;
  logic [31:0]    xsh;
  logic [35:0]    rem_div;
  logic [35:0]    rem_sq;
  logic [31:0]    divisor;
  logic [65:0]    psh;
  logic [32:0]    dval;
  logic [32:0]    dmag_nxt;
  logic           out_free;

  rmv_alu u_alu (.req(req), .y(y));

  assign xs       = in_ch.sample_value << ShAmt;
  assign xsh      = $signed(xs) >>> ShAmt;
  assign rem_div  = {rem_r[34:0], wq_r[65]};
  assign rem_sq   = {rem_r[33:0], wq_r[65:64]};
  assign divisor  = (state_r == S_DIV2) ? (cnt_r - 32'd1) : cnt_r;
  assign psh      = wq_r >> FRAC_BITS;
  assign dval     = y[32:0];
  assign dmag_nxt = dval[32] ? (33'd0 - dval) : dval;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    req = '0;
    unique case (state_r)
      S_DELTA, S_ERR: begin
        req.a   = {{35{x_r[32]}}, x_r};
        req.b   = {{36{mean_r[31]}}, mean_r};
        req.sub = 1'b1;
      end
      S_DIV1, S_DIV2: begin
        req.a   = {32'd0, rem_div};
        req.b   = {36'd0, divisor};
        req.sub = 1'b1;
      end
      S_MEAN: begin
        req.a   = {{36{mean_r[31]}}, mean_r};
        req.b   = {35'd0, wq_r[32:0]};
        req.sub = dneg_r;
      end
      S_MUL: begin
        req.a   = {35'd0, wq_r[65:33]};
        req.b   = {35'd0, dmag_r};
        req.sub = 1'b0;
      end
      S_ACC: begin
        req.a   = {4'd0, m2_r};
        req.b   = {4'd0, psh[63:0]};
        req.sub = 1'b0;
      end
      S_SQRT: begin
        req.a   = {32'd0, rem_sq};
        req.b   = {34'd0, root_r, 2'b01};
        req.sub = 1'b1;
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mean_r      <= '0;
      m2_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_r <= {xsh[31], xsh};
            if (cnt_r != 32'hFFFF_FFFF) cnt_r <= cnt_r + 32'd1;
            state_r <= S_DELTA;
          end
        end
        S_DELTA: begin
          dneg_r  <= dval[32];
          dmag_r  <= dmag_nxt;
          wq_r    <= {dmag_nxt, 33'd0};
          rem_r   <= '0;
          iter_r  <= 7'd33;
          state_r <= S_DIV1;
        end
        S_DIV1, S_DIV2: begin
          if (iter_r == 7'd1 && state_r == S_DIV2) begin
            var_r   <= y[AluW-1] ? {wq_r[62:0], 1'b0} : {wq_r[62:0], 1'b1};
            wq_r    <= y[AluW-1] ? {wq_r[62:0], 3'b000} : {wq_r[62:0], 3'b100};
            rem_r   <= '0;
            root_r  <= '0;
            iter_r  <= 7'd32;
            state_r <= S_SQRT;
          end else begin
            if (y[AluW-1]) begin
              rem_r <= rem_div;
              wq_r  <= {wq_r[64:0], 1'b0};
            end else begin
              rem_r <= y[35:0];
              wq_r  <= {wq_r[64:0], 1'b1};
            end
            iter_r <= iter_r - 7'd1;
            if (iter_r == 7'd1) state_r <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean_r  <= y[31:0];
          state_r <= S_ERR;
        end
        S_ERR: begin
          wq_r    <= {33'd0, dmag_nxt};
          iter_r  <= 7'd33;
          state_r <= S_MUL;
        end
        S_MUL: begin
          wq_r   <= wq_r[0] ? {y[33:0], wq_r[32:1]} : {1'b0, wq_r[65:1]};
          iter_r <= iter_r - 7'd1;
          if (iter_r == 7'd1) state_r <= S_ACC;
        end
        S_ACC: begin
          if (y[64] || (|psh[65:64])) m2_r <= '1;
          else m2_r <= y[63:0];
          if (cnt_r >= 32'd2) begin
            wq_r    <= {((y[64] || (|psh[65:64])) ? 64'hFFFF_FFFF_FFFF_FFFF : y[63:0]),
                        2'b00};
            rem_r   <= '0;
            iter_r  <= 7'd64;
            state_r <= S_DIV2;
          end else begin
            var_r   <= '0;
            root_r  <= '0;
            state_r <= S_DONE;
          end
        end
        S_SQRT: begin
          if (y[AluW-1]) begin
            rem_r  <= rem_sq;
            root_r <= {root_r[30:0], 1'b0};
          end else begin
            rem_r  <= y[35:0];
            root_r <= {root_r[30:0], 1'b1};
          end
          wq_r   <= {wq_r[63:0], 2'b00};
          iter_r <= iter_r - 7'd1;
          if (iter_r == 7'd1) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            o_cnt_r     <= cnt_r;
            o_mean_r    <= mean_r;
            o_var_r     <= var_r;
            o_sd_r      <= root_r;
            o_vv_r      <= (cnt_r >= 32'd2);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.sample_count    = o_cnt_r;
  assign out_ch.mean_value      = o_mean_r;
  assign out_ch.sample_variance = o_var_r;
  assign out_ch.std_deviation   = o_sd_r;
  assign out_ch.variance_valid  = o_vv_r;

endmodule

// File: src/running_mean_variance.sv
// running_mean_variance: top level of the welford running statistics block
// sequence: a 33-step divide and a 33-step multiply, then with two or more samples a 64-step
// divide and a 32-step sqrt, all on one shared adder
// input: a new beat is taken only after the previous result is registered, later while the output stalls
// reset: synchronous active-low rst_n clears count, mean and m2 to zero
// depends on rmv_pkg, rmv_if, rmv_core

module running_mean_variance #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  rmv_in_if.sink    in_ch,
  rmv_out_if.source out_ch
);
  import rmv_pkg::*;

  rmv_core #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_vv_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.variance_valid |-> out_ch.sample_count >= 32'd2)
    else $error("variance flagged with fewer than two samples");
  a_var_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.variance_valid |->
      out_ch.sample_variance == 64'd0 && out_ch.std_deviation == 32'd0)
    else $error("variance nonzero with fewer than two samples");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while busy");
`endif

endmodule
